FILE: hw/rtl/line_command_telemetry_parser_assert.svh
// ============================================================================
// Assertion macros for the line command telemetry parser
// Concurrent checks that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef LINE_COMMAND_TELEMETRY_PARSER_ASSERT_SVH
`define LINE_COMMAND_TELEMETRY_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is high.
`define LCTP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds across reset.
`define LCTP_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCTP_ASSERT(lbl, clk, rst, prop, msg)
`define LCTP_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/lctp_pkg.sv
// ============================================================================
// lctp_pkg
// Shared constants, types and the digit decoder of the telemetry parser.
// ============================================================================
package lctp_pkg;

   localparam int BUFFER_BYTES_DEF = 32;
   localparam int MAX_RESULTS      = 32;
   localparam int CNT_W            = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_HEADING = 8'h68;   // 'h'
   localparam logic [7:0] CHAR_DEPTH   = 8'h64;   // 'd'
   localparam logic [7:0] CHAR_POWER   = 8'h70;   // 'p'
   localparam logic [7:0] CHAR_DEAD    = 8'h6C;   // 'l'
   localparam logic [7:0] CHAR_ALIVE   = 8'h6B;   // 'k'
   localparam logic [7:0] DIGIT_BASE   = 8'h20;
   localparam logic [7:0] DIGIT_TOP    = 8'h5F;

   localparam logic [1:0] KIND_HEADING = 2'd0;
   localparam logic [1:0] KIND_DEPTH   = 2'd1;
   localparam logic [1:0] KIND_POWER   = 2'd2;
   localparam logic [1:0] KIND_KILL    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CMD,
      ST_HI,
      ST_LO,
      ST_DONE
   } lctp_state_type;

   // Controls from the scan sequencer to the message buffer.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic rd_in_range;
      logic clear;
   } lctp_buf_ctrl_type;

   typedef struct packed {
      logic       bad;
      logic [5:0] val;
   } lctp_digit_type;

   // A digit keeps the low six bits of its offset from the digit base.
   function automatic lctp_digit_type lctp_decode_digit(input logic [7:0] b);
      lctp_digit_type d;
      logic [7:0]     diff;
      diff  = b - DIGIT_BASE;
      d.bad = (b < DIGIT_BASE) || (b > DIGIT_TOP);
      d.val = diff[5:0];
      return d;
   endfunction

endpackage

FILE: hw/rtl/lctp_msg_buf.sv
// ============================================================================
// lctp_msg_buf
// Message byte store with a registered read and per-entry valid bits.
// ============================================================================
module lctp_msg_buf
   import lctp_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
   parameter int AW           = $clog2(BUFFER_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  lctp_buf_ctrl_type ctrl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [7:0]        rd_byte
);

   logic [7:0]              mem [BUFFER_BYTES];
   logic [BUFFER_BYTES-1:0] vld_ff, vld_in;
   logic [7:0]              rd_data_ff;
   logic                    rd_ok_ff;

   // Entries never written since the last clear read as zero.
   always_comb begin
      vld_in = vld_ff;
      if (ctrl.clear) begin
         vld_in = '0;
      end else if (ctrl.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else if (ctrl.rd_en) begin
         rd_ok_ff <= ctrl.rd_in_range && vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_byte = rd_ok_ff ? rd_data_ff : CHAR_NUL;

endmodule

FILE: hw/rtl/line_command_telemetry_parser.sv
// ============================================================================
// line_command_telemetry_parser
// Buffers received serial bytes and decodes the telemetry commands of each
// newline-terminated message into heading, depth, power and kill updates.
// ============================================================================
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   req_rx_byte
//   rsp_      out        rsp_valid / rsp_stall   rsp_field_kind, rsp_field_value,
//                                                rsp_digit_error, rsp_last_update
//
// An ordinary byte is written into the message buffer in the cycle of its
// transfer, so such bytes can be taken back to back.
// A newline starts a scan that walks the buffer memory through its single
// registered read port: a skipped byte is fetched and checked, a command
// with two digits has its command byte and then each digit read in turn,
// and the scan ends in a done state; an update can wait while the result
// side stalls. req_stall is high for the whole scan.
// Reset is synchronous and clears the per-entry valid bits at once; there is
// no clearing pass. A held result in the output register never blocks the
// input side while the block is idle.
//
module line_command_telemetry_parser
   import lctp_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_field_kind,
   output logic [11:0] rsp_field_value,
   output logic        rsp_digit_error,
   output logic        rsp_last_update
);

`include "line_command_telemetry_parser_assert.svh"

   // Address width of the buffer, and a scan position wide enough to run
   // two bytes past the buffer end while a command's digits are fetched.
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int PW = $clog2(BUFFER_BYTES + 3);

   localparam logic [PW-1:0] POS_END  = PW'(BUFFER_BYTES);
   localparam logic [AW-1:0] WP_LAST  = AW'(BUFFER_BYTES - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

   lctp_state_type state_ff, state_in;

   logic [PW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       kind_ff, kind_in;
   logic [5:0]       hi_ff, hi_in;
   logic             err_ff, err_in;

   // One decoded update is held back so that the final one of a message can
   // be marked as last before it leaves.
   logic             pend_vld_ff, pend_vld_in;
   logic [1:0]       pend_kind_ff, pend_kind_in;
   logic [11:0]      pend_val_ff, pend_val_in;
   logic             pend_err_ff, pend_err_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [11:0]      rsp_val_ff, rsp_val_in;
   logic             rsp_err_ff, rsp_err_in;
   logic             rsp_last_ff, rsp_last_in;

   lctp_buf_ctrl_type buf_ctrl;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_byte;

   logic             out_free;
   logic             can_emit;
   logic             emit;
   logic [1:0]       emit_kind;
   logic [11:0]      emit_val;
   logic             emit_err;
   logic             emit_final;
   logic [CNT_W-1:0] cnt_inc;
   logic [PW-1:0]    pos_p1, pos_p2, pos_p3;
   lctp_digit_type   dig;

   lctp_msg_buf #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .AW           (AW)
   ) u_msg_buf (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (buf_ctrl),
      .wr_addr (wp_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_byte (rd_byte)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_emit   = !pend_vld_ff || out_free;
   assign cnt_inc    = cnt_ff + CNT_W'(1);
   assign emit_final = (cnt_inc == CNT_MAX);
   assign pos_p1     = pos_ff + PW'(1);
   assign pos_p2     = pos_ff + PW'(2);
   assign pos_p3     = pos_ff + PW'(3);
   assign dig        = lctp_decode_digit(rd_byte);

   // Scan sequencer: the position register points at the command byte, and
   // its digits are read at the two following positions.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      hi_in        = hi_ff;
      err_in       = err_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_val_in  = pend_val_ff;
      pend_err_in  = pend_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      buf_ctrl     = '0;
      rd_addr      = pos_ff[AW-1:0];
      emit         = 1'b0;
      emit_kind    = KIND_KILL;
      emit_val     = '0;
      emit_err     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               buf_ctrl.wr_en = 1'b1;
               if (req_rx_byte == CHAR_NEWLINE) begin
                  pos_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_FETCH;
               end else begin
                  wp_in = (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);
               end
            end
         end

         ST_FETCH: begin
            if (pos_ff >= POS_END) begin
               state_in = ST_DONE;
            end else begin
               buf_ctrl.rd_en       = 1'b1;
               buf_ctrl.rd_in_range = 1'b1;
               state_in             = ST_CMD;
            end
         end

         ST_CMD: begin
            priority if (rd_byte == CHAR_NUL) begin
               state_in = ST_DONE;
            end else if (rd_byte == CHAR_HEADING || rd_byte == CHAR_DEPTH ||
                         rd_byte == CHAR_POWER) begin
               priority if (rd_byte == CHAR_HEADING) begin
                  kind_in = KIND_HEADING;
               end else if (rd_byte == CHAR_DEPTH) begin
                  kind_in = KIND_DEPTH;
               end else begin
                  kind_in = KIND_POWER;
               end
               buf_ctrl.rd_en       = 1'b1;
               buf_ctrl.rd_in_range = (pos_p1 < POS_END);
               rd_addr              = pos_p1[AW-1:0];
               state_in             = ST_HI;
            end else if (rd_byte == CHAR_DEAD || rd_byte == CHAR_ALIVE) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  emit_val = (rd_byte == CHAR_ALIVE) ? 12'd1 : 12'd0;
                  pos_in   = pos_p1;
                  state_in = emit_final ? ST_DONE : ST_FETCH;
               end
            end else begin
               pos_in   = pos_p1;
               state_in = ST_FETCH;
            end
         end

         ST_HI: begin
            hi_in                = dig.val;
            err_in               = dig.bad;
            buf_ctrl.rd_en       = 1'b1;
            buf_ctrl.rd_in_range = (pos_p2 < POS_END);
            rd_addr              = pos_p2[AW-1:0];
            state_in             = ST_LO;
         end

         ST_LO: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_kind = kind_ff;
               emit_val  = {hi_ff, dig.val};
               emit_err  = err_ff || dig.bad;
               pos_in    = pos_p3;
               state_in  = emit_final ? ST_DONE : ST_FETCH;
            end
         end

         ST_DONE: begin
            // The held update, if any, leaves marked as last; the buffer is
            // then emptied for the next message.
            if (can_emit) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_val_in   = pend_val_ff;
                  rsp_err_in   = pend_err_ff;
                  rsp_last_in  = 1'b1;
               end
               pend_vld_in    = 1'b0;
               buf_ctrl.clear = 1'b1;
               wp_in          = '0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new update pushes the held one out to the output register.
      if (emit) begin
         if (pend_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = pend_kind_ff;
            rsp_val_in   = pend_val_ff;
            rsp_err_in   = pend_err_ff;
            rsp_last_in  = 1'b0;
         end
         pend_vld_in  = 1'b1;
         pend_kind_in = emit_kind;
         pend_val_in  = emit_val;
         pend_err_in  = emit_err;
         cnt_in       = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      kind_ff      <= kind_in;
      hi_ff        <= hi_in;
      err_ff       <= err_in;
      pend_kind_ff <= pend_kind_in;
      pend_val_ff  <= pend_val_in;
      pend_err_ff  <= pend_err_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // New bytes are taken only between scans.
   assign req_stall       = (state_ff != ST_IDLE);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_kind  = rsp_kind_ff;
   assign rsp_field_value = rsp_val_ff;
   assign rsp_digit_error = rsp_err_ff;
   assign rsp_last_update = rsp_last_ff;

   `LCTP_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_MAX, "update count above limit")
   `LCTP_ASSERT(a_idle_no_pend, clock, reset, (state_ff == ST_IDLE) |-> !pend_vld_ff, "update held while idle")
   `LCTP_ASSERT(a_pend_counted, clock, reset, pend_vld_ff |-> (cnt_ff != '0), "held update not counted")
   `LCTP_ASSERT(a_done_to_idle, clock, reset, (state_ff == ST_DONE && can_emit) |=> (state_ff == ST_IDLE && wp_ff == '0), "scan end did not return to idle")
   `LCTP_ASSERT_RST(a_reset_state, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff && wp_ff == '0), "reset state wrong")

endmodule

FILE: tb/telemetry_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry update checker
// Watches the byte and update channels of the parser, predicts the updates
// of every newline-terminated message and compares them field by field.
// ----------------------------------------------------------------------------
module telemetry_update_checker
   import lctp_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_field_kind,
   input  logic [11:0] rsp_field_value,
   input  logic        rsp_digit_error,
   input  logic        rsp_last_update,

   output int unsigned mismatch_count,
   output int unsigned updates_pending
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] value;
      logic        digit_error;
      logic        last_update;
   } telemetry_update_type;

   telemetry_update_type update_queue[$];
   telemetry_update_type want;
   logic [7:0]           line_buf [BUFFER_BYTES];
   int unsigned          line_wr_pos;
   int unsigned          mismatches;

   function automatic logic digit_bad(input logic [7:0] b);
      return (b < DIGIT_BASE) || (b > DIGIT_TOP);
   endfunction

   function automatic logic [5:0] digit_val(input logic [7:0] b);
      logic [7:0] offset;
      offset = b - DIGIT_BASE;
      return offset[5:0];
   endfunction

   // Positions past the end of the buffer read as zero.
   function automatic logic [7:0] byte_at(input int unsigned idx);
      if (idx >= BUFFER_BYTES) return CHAR_NUL;
      return line_buf[idx];
   endfunction

   task automatic clear_line();
      for (int i = 0; i < BUFFER_BYTES; i++) line_buf[i] = CHAR_NUL;
      line_wr_pos = 0;
   endtask

   // Walks the buffer from the start like the hardware scan does and queues
   // one update per command, marking the final one of the message.
   task automatic decode_line();
      telemetry_update_type found[$];
      telemetry_update_type upd;
      logic [7:0]           c;
      logic [7:0]           hi_b;
      logic [7:0]           lo_b;
      logic                 hit;
      int unsigned          pos;
      pos = 0;
      while (pos < BUFFER_BYTES && line_buf[pos] != CHAR_NUL) begin
         c   = line_buf[pos];
         upd = '0;
         hit = 1'b0;
         if (c == CHAR_HEADING || c == CHAR_DEPTH || c == CHAR_POWER) begin
            hi_b            = byte_at(pos + 1);
            lo_b            = byte_at(pos + 2);
            upd.kind        = (c == CHAR_HEADING) ? KIND_HEADING :
                              (c == CHAR_DEPTH) ? KIND_DEPTH : KIND_POWER;
            upd.value       = {digit_val(hi_b), digit_val(lo_b)};
            upd.digit_error = digit_bad(hi_b) || digit_bad(lo_b);
            hit             = 1'b1;
            pos += 3;
         end else begin
            if (c == CHAR_DEAD || c == CHAR_ALIVE) begin
               upd.kind  = KIND_KILL;
               upd.value = (c == CHAR_ALIVE) ? 12'd1 : 12'd0;
               hit       = 1'b1;
            end
            pos += 1;
         end
         if (hit && found.size() < MAX_RESULTS) found.push_back(upd);
      end
      if (found.size() != 0) begin
         upd = found.pop_back();
         upd.last_update = 1'b1;
         found.push_back(upd);
      end
      foreach (found[n]) update_queue.push_back(found[n]);
   endtask

   task automatic take_byte(input logic [7:0] b);
      if (line_wr_pos >= BUFFER_BYTES) line_wr_pos = 0;
      line_buf[line_wr_pos] = b;
      if (b == CHAR_NEWLINE) begin
         decode_line();
         clear_line();
      end else begin
         line_wr_pos = (line_wr_pos + 1) % BUFFER_BYTES;
      end
   endtask

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned got_val);
      if (exp_val != got_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, name, exp_val, got_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         update_queue.delete();
         clear_line();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) take_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (update_queue.size() == 0) begin
               $display({"%0t: unexpected update: expected none, ",
                         "actual kind %0d value %0d error %0d last %0d"},
                        $time, rsp_field_kind, rsp_field_value, rsp_digit_error,
                        rsp_last_update);
               mismatches++;
            end else begin
               want = update_queue.pop_front();
               check_field("field_kind", 32'(want.kind), 32'(rsp_field_kind));
               check_field("field_value", 32'(want.value), 32'(rsp_field_value));
               check_field("digit_error", 32'(want.digit_error),
                           32'(rsp_digit_error));
               check_field("last_update", 32'(want.last_update),
                           32'(rsp_last_update));
            end
         end
      end
      mismatch_count  <= mismatches;
      updates_pending <= update_queue.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line command telemetry parser testbench
// Feeds the parser with serial byte messages, directed ones first and then
// random ones shaped as command lines, lines that run into the buffer end,
// wrapping lines, noise and runs of kill commands. A checker beside the
// parser predicts and compares every update; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import lctp_pkg::*;

   localparam int BUF_BYTES       = BUFFER_BYTES_DEF;
   localparam int ITEM_TARGET     = 410;
   // From this many bytes on, neither side idles any more.
   localparam int QUIET_AFTER     = 340;
   // The long receiver hold-off starts after this many byte transfers.
   localparam int PRESSURE_AT     = 80;
   localparam int PRESSURE_CYCLES = 400;
   // The drain wait is sized for the scan of a full buffer.
   localparam int DRAIN_CYCLES    = 2 * BUF_BYTES + 16;
   // The longest correct stretch without any transfer is the hold-off above;
   // the limit leaves a wide margin over it.
   localparam int WATCHDOG_LIMIT  = 4000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        quiet       = 1'b0;

   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_field_kind;
   logic [11:0] rsp_field_value;
   logic        rsp_digit_error;
   logic        rsp_last_update;

   int unsigned mismatch_count;
   int unsigned updates_pending;
   int unsigned byte_transfers;
   int unsigned idle_cycles;
   int unsigned bytes_sent;
   int unsigned stall_left;
   bit          pressure_done;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   line_command_telemetry_parser #(
      .BUFFER_BYTES(BUF_BYTES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_field_kind (rsp_field_kind),
      .rsp_field_value(rsp_field_value),
      .rsp_digit_error(rsp_digit_error),
      .rsp_last_update(rsp_last_update)
   );

   telemetry_update_checker #(
      .BUFFER_BYTES(BUF_BYTES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_field_kind (rsp_field_kind),
      .rsp_field_value(rsp_field_value),
      .rsp_digit_error(rsp_digit_error),
      .rsp_last_update(rsp_last_update),
      .mismatch_count (mismatch_count),
      .updates_pending(updates_pending)
   );

   // The watchdog counts cycles in which no transfer happens on either
   // channel. A correct parser never goes quiet for that long, so reaching
   // the limit means it has hung.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles    <= 0;
         byte_transfers <= 0;
      end else begin
         if (req_valid && !req_stall) byte_transfers <= byte_transfers + 1;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == WATCHDOG_LIMIT - 1) begin
            $display("** line_command_telemetry_parser: FAILED **");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // The update receiver stalls in random bursts. Once, after enough byte
   // transfers, it holds off for a long stretch while the sender keeps
   // offering bytes, so that a scan backs up into the input.
   // In the closing part of the run it never stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         stall_left    = 0;
         pressure_done = 1'b0;
      end else if (!pressure_done && byte_transfers >= PRESSURE_AT) begin
         pressure_done = 1'b1;
         stall_left    = PRESSURE_CYCLES - 1;
         rsp_stall     <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one byte and returns at the edge of its transfer. A random gap
   // may come first; valid stays high from one byte to the next when there
   // is no gap, and the byte is held while stalled.
   task automatic push_byte(input logic [7:0] b);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      bytes_sent++;
   endtask

   // Any byte but the newline, so that it cannot end the message early.
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_NEWLINE) b = ~b;
      return b;
   endfunction

   // A byte that is no newline, no zero and no digit command; it may be a kill command.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = body_byte();
      if (b == CHAR_NUL || b == CHAR_HEADING || b == CHAR_DEPTH || b == CHAR_POWER)
         b = CHAR_DEAD;
      return b;
   endfunction

   function automatic logic [7:0] command_letter();
      case ($urandom_range(0, 2))
         0:       return CHAR_HEADING;
         1:       return CHAR_DEPTH;
         default: return CHAR_POWER;
      endcase
   endfunction

   // Mostly a proper base-64 digit; now and then any byte but the newline, zero included.
   function automatic logic [7:0] digit_byte();
      if ($urandom_range(0, 7) == 0) return body_byte();
      return 8'($urandom_range(DIGIT_BASE, DIGIT_TOP));
   endfunction

   function automatic logic [7:0] kill_letter();
      return $urandom_range(0, 1) ? CHAR_DEAD : CHAR_ALIVE;
   endfunction

   // A command message: digit commands, kill commands and the odd plain
   // byte, short enough not to wrap, then the newline.
   task automatic send_command_line();
      int unsigned room;
      int unsigned pick;
      room = $urandom_range(1, BUF_BYTES - 1);
      while (room > 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 6 && room >= 3) begin
            push_byte(command_letter());
            push_byte(digit_byte());
            push_byte(digit_byte());
            room -= 3;
         end else if (pick < 9) begin
            push_byte(kill_letter());
            room--;
         end else begin
            push_byte(plain_byte());
            room--;
         end
      end
      push_byte(CHAR_NEWLINE);
   endtask

   // A message whose last digit command sits at the buffer end, so that its
   // digits are the newline itself, cleared entries or positions past the
   // end. With a full buffer the newline wraps onto the first entry.
   task automatic send_tail_line();
      int unsigned len;
      len = $urandom_range(BUF_BYTES - 2, BUF_BYTES);
      repeat (len - 1) push_byte($urandom_range(0, 3) == 0 ? kill_letter() : plain_byte());
      push_byte($urandom_range(0, 5) == 0 ? kill_letter() : command_letter());
      push_byte(CHAR_NEWLINE);
   endtask

   // A run of arbitrary bytes longer than the buffer, so the write position
   // wraps before the newline arrives.
   task automatic send_wrap_line();
      repeat ($urandom_range(BUF_BYTES + 1, 2 * BUF_BYTES + 6)) push_byte(body_byte());
      push_byte(CHAR_NEWLINE);
   endtask

   // A few arbitrary bytes, possibly none, then the newline.
   task automatic send_noise_line();
      repeat ($urandom_range(0, 8)) push_byte(body_byte());
      push_byte(CHAR_NEWLINE);
   endtask

   // The most updates one message can carry: kill commands up to the entry
   // before the newline.
   task automatic send_kill_line();
      repeat (BUF_BYTES - 1) push_byte(kill_letter());
      push_byte(CHAR_NEWLINE);
   endtask

   initial begin
      bytes_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // An empty message gives no update at all.
      push_byte(CHAR_NEWLINE);
      // Heading at the largest value, depth at zero, power with a digit on
      // each side of the legal range, a skipped 0xFF, both kill commands,
      // and then a zero byte that hides the heading stored behind it.
      push_byte(CHAR_HEADING);
      push_byte(DIGIT_TOP);
      push_byte(DIGIT_TOP);
      push_byte(CHAR_DEPTH);
      push_byte(DIGIT_BASE);
      push_byte(DIGIT_BASE);
      push_byte(CHAR_POWER);
      push_byte(DIGIT_BASE - 8'd1);
      push_byte(DIGIT_TOP + 8'd1);
      push_byte(8'hFF);
      push_byte(CHAR_DEAD);
      push_byte(CHAR_ALIVE);
      push_byte(CHAR_NUL);
      push_byte(CHAR_HEADING);
      push_byte(CHAR_NEWLINE);

      // Random messages, mostly well formed, until the byte budget is used.
      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= QUIET_AFTER) quiet <= 1'b1;
         case ($urandom_range(0, 9))
            5:       send_tail_line();
            6:       send_wrap_line();
            7:       send_noise_line();
            8:       send_kill_line();
            default: send_command_line();
         endcase
      end
      req_valid <= 1'b0;

      // The pending count is a registered copy of the checker's queue size.
      @(posedge clock);
      while (updates_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && updates_pending == 0) begin
         $display("** line_command_telemetry_parser: PASSED **");
      end else begin
         $display("** line_command_telemetry_parser: FAILED **");
      end
      $finish;
   end

endmodule
